// File: hw/rtl/rdc_pkg.sv
// Shared types, constants and calendar helpers for the RTC date converter.
// Used by rdc_prep, rdc_cell and rtc_day_count_date_converter_top; no dependencies.
`timescale 1ns / 1ps

package rdc_pkg;

    // Field widths of the stream payloads
    localparam int DayW  = 9;
    localparam int YearW = 12;
    localparam int MonW  = 4;
    localparam int MdayW = 5;
    localparam int HourW = 5;
    localparam int MinW  = 6;
    localparam int SecW  = 6;

    // Packed stream widths (tdata padded to whole bytes)
    localparam int InDataW  = 48;
    localparam int OutDataW = 48;
    localparam int CfgW     = YearW;

    // Number of month-step cells; 17 consecutive months always exceed 511 days
    localparam int NumCells = 16;

    localparam logic [YearW-1:0] EpochReset = 12'd1970;
    localparam logic [MonW-1:0]  MonLast    = 4'd11;
    localparam logic [HourW-1:0] HourMax    = 5'd23;
    localparam logic [MinW-1:0]  MinMax     = 6'd59;
    localparam logic [SecW-1:0]  SecMax     = 6'd59;
    localparam logic [8:0]       DaysPerYear = 9'd365;

    // Reciprocal of 25 scaled by 2^17, exact for inputs below 8192
    localparam logic [25:0] Div25Mul   = 26'd5243;
    localparam int          Div25Shift = 17;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    // One transaction as it travels along the cell row
    typedef struct packed {
        op_t              op;
        logic             bad;
        logic [DayW-1:0]  days;
        logic [MonW-1:0]  mon_tgt;
        logic [MonW-1:0]  mon;
        logic [YearW-1:0] year;
        logic             leap;
        logic             leap_next;
        logic [HourW-1:0] hour;
        logic [MinW-1:0]  minute;
        logic [SecW-1:0]  second;
    } rdc_item_t;

    // Length of month m (0..11); codes above 11 are never stepped through
    function automatic logic [MdayW-1:0] month_len(input logic [MonW-1:0] m,
                                                   input logic leap);
        logic [MdayW-1:0] len;
        unique case (m)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Floor of x / 25 by reciprocal multiply
    function automatic logic [8:0] div25(input logic [12:0] x);
        logic [25:0] prod;
        prod = 26'(x) * Div25Mul;
        return prod[Div25Shift+8:Div25Shift];
    endfunction

    // Gregorian leap test, given q = floor(y / 25)
    function automatic logic is_leap(input logic [12:0] y, input logic [8:0] q);
        logic [12:0] rem;
        logic        by25;
        rem  = y - 13'(q * 13'd25);
        by25 = (rem == 13'd0);
        return (y[1:0] == 2'd0) && (!by25 || (y[3:0] == 4'd0));
    endfunction

endpackage

// File: hw/rtl/rdc_cell.sv
// One month-step cell of the converter row: steps a transaction by at most one month.
// Depends on rdc_pkg.
`timescale 1ns / 1ps

module rdc_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  rdc_pkg::rdc_item_t in_item,
    output logic              out_valid,
    output rdc_pkg::rdc_item_t out_item
);
    import rdc_pkg::*;

    logic             valid_reg;
    rdc_item_t        item_reg;
    rdc_item_t        item_next;
    logic [MdayW-1:0] len;

    // Subtract one month's days on decode while the count covers them, add one month on encode below mon_tgt
    always_comb begin
        len       = month_len(in_item.mon, in_item.leap);
        item_next = in_item;
        unique case (in_item.op)
            OP_DECODE: begin
                if (in_item.days >= DayW'(len)) begin
                    item_next.days = in_item.days - DayW'(len);
                    if (in_item.mon == MonLast) begin
                        item_next.mon  = '0;
                        item_next.year = in_item.year + 1'b1;
                        item_next.leap = in_item.leap_next;
                    end else begin
                        item_next.mon = in_item.mon + 1'b1;
                    end
                end
            end
            OP_ENCODE: begin
                if (in_item.mon < in_item.mon_tgt) begin
                    item_next.days = in_item.days + DayW'(len);
                    item_next.mon  = in_item.mon + 1'b1;
                end
            end
        endcase
    end

    // Advance the row in lockstep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

`ifndef SYNTH
    a_enc_no_overshoot: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && (item_reg.op == OP_ENCODE) |-> item_reg.mon <= item_reg.mon_tgt)
        else $error("encode month walk passed its target");
`endif

endmodule

// File: hw/rtl/rdc_prep.sv
// Two-stage front end: range checks, leap flags, year and leap-day offsets.
// Depends on rdc_pkg; feeds the first rdc_cell.
`timescale 1ns / 1ps

module rdc_prep (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  logic                      in_valid,
    input  rdc_pkg::op_t              op,
    input  logic [rdc_pkg::YearW-1:0] year,
    input  logic [rdc_pkg::MonW-1:0]  month,
    input  logic [rdc_pkg::MdayW-1:0] mday,
    input  logic [rdc_pkg::HourW-1:0] hour,
    input  logic [rdc_pkg::MinW-1:0]  minute,
    input  logic [rdc_pkg::SecW-1:0]  second,
    input  logic [rdc_pkg::DayW-1:0]  day_count,
    input  logic [rdc_pkg::YearW-1:0] epoch_year,
    output logic                      out_valid,
    output rdc_pkg::rdc_item_t        out_item
);
    import rdc_pkg::*;

    // Stage one: quotients by 25, year product, early range checks
    logic             s1_valid_reg;
    op_t              s1_op_reg;
    logic [YearW-1:0] s1_y0_reg;
    logic [12:0]      s1_y1_reg;
    logic [8:0]       s1_q_y0_reg, s1_q_y1_reg;
    logic [9:0]       s1_yq4_reg, s1_eq4_reg;
    logic [8:0]       s1_yq100_reg, s1_yq400_reg, s1_eq100_reg, s1_eq400_reg;
    logic [DayW-1:0]  s1_yd365_reg;
    logic             s1_bad_reg;
    logic [MonW-1:0]  s1_month_reg;
    logic [MdayW-1:0] s1_mday_reg;
    logic [HourW-1:0] s1_hour_reg;
    logic [MinW-1:0]  s1_minute_reg;
    logic [SecW-1:0]  s1_second_reg;
    logic [DayW-1:0]  s1_day_count_reg;

    logic [YearW-1:0] y0, py, pe, ydiff;
    logic [12:0]      y1;
    logic             early_bad;

    always_comb begin
        y0    = (op == OP_DECODE) ? epoch_year : year;
        y1    = {1'b0, y0} + 13'd1;
        py    = year - 1'b1;
        pe    = epoch_year - 1'b1;
        ydiff = year - epoch_year;
        early_bad = (year < epoch_year) || (month > MonLast) || (mday == '0) ||
                    (hour > HourMax) || (minute > MinMax) || (second > SecMax);
    end

    // Register stage one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_op_reg    <= op;
            s1_y0_reg    <= y0;
            s1_y1_reg    <= y1;
            s1_q_y0_reg  <= div25({1'b0, y0});
            s1_q_y1_reg  <= div25(y1);
            // Leap years before year zero count as none
            s1_yq4_reg   <= (year == '0) ? '0 : py[11:2];
            s1_yq100_reg <= (year == '0) ? '0 : div25(13'(py[11:2]));
            s1_yq400_reg <= (year == '0) ? '0 : div25(13'(py[11:4]));
            s1_eq4_reg   <= (epoch_year == '0) ? '0 : pe[11:2];
            s1_eq100_reg <= (epoch_year == '0) ? '0 : div25(13'(pe[11:2]));
            s1_eq400_reg <= (epoch_year == '0) ? '0 : div25(13'(pe[11:4]));
            s1_yd365_reg <= DayW'(18'(ydiff[8:0]) * 18'(DaysPerYear));
            s1_bad_reg   <= early_bad;
            s1_month_reg <= month;
            s1_mday_reg  <= mday;
            s1_hour_reg  <= hour;
            s1_minute_reg <= minute;
            s1_second_reg <= second;
            s1_day_count_reg <= day_count;
        end
    end

    // Stage two: leap flags, day-of-month check, starting day count
    logic            leap0, leap1, bad;
    logic [DayW-1:0] lb_y, lb_e, enc_days;
    rdc_item_t       item_next;
    logic             s2_valid_reg;
    rdc_item_t        s2_item_reg;

    always_comb begin
        leap0    = is_leap({1'b0, s1_y0_reg}, s1_q_y0_reg);
        leap1    = is_leap(s1_y1_reg, s1_q_y1_reg);
        lb_y     = DayW'(s1_yq4_reg) - DayW'(s1_yq100_reg) + DayW'(s1_yq400_reg);
        lb_e     = DayW'(s1_eq4_reg) - DayW'(s1_eq100_reg) + DayW'(s1_eq400_reg);
        enc_days = s1_yd365_reg + lb_y - lb_e + DayW'(s1_mday_reg) - 1'b1;
        bad      = (s1_op_reg == OP_ENCODE) &&
                   (s1_bad_reg || (s1_mday_reg > month_len(s1_month_reg, leap0)));

        item_next.op        = s1_op_reg;
        item_next.bad       = bad;
        item_next.days      = (s1_op_reg == OP_DECODE) ? s1_day_count_reg : enc_days;
        item_next.mon_tgt   = ((s1_op_reg == OP_ENCODE) && !bad) ? s1_month_reg : '0;
        item_next.mon       = '0;
        item_next.year      = s1_y0_reg;
        item_next.leap      = leap0;
        item_next.leap_next = leap1;
        item_next.hour      = s1_hour_reg;
        item_next.minute    = s1_minute_reg;
        item_next.second    = s1_second_reg;
    end

    // Register stage two
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_item_reg <= item_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

// File: hw/rtl/rtc_day_count_date_converter_top.sv
// Top level of the RTC day-count / calendar date converter.
// Depends on rdc_pkg, rdc_prep and rdc_cell.
`timescale 1ns / 1ps

// Each transaction passes through two front-end stages,
// a row of 16 month-step cells (one month per cell, so a decode of a count up
// to 511 days finishes within the row), and an output register. The row moves
// in lockstep, so a new transaction is taken every cycle while the result side
// accepts; when a result sits untaken the whole row holds and s_axis_tready
// drops. Encode (tuser = 0) checks the date and time and returns days since
// epoch_year; decode (tuser = 1) returns year, month and day of month. Write
// epoch_year on the cfg channel only while no transaction is in flight.
module rtc_day_count_date_converter_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration: epoch_year
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rdc_pkg::CfgW-1:0]     cfg_data,
    // Input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: year[11:0], month[15:12], mday[20:16], hour[25:21], minute[31:26],
    //        second[37:32], day_count[46:38], zero[47]
    input  logic [rdc_pkg::InDataW-1:0]  s_axis_tdata,
    // tuser: op[0]
    input  logic [0:0]                   s_axis_tuser,
    // Result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // tdata: day_count_out[8:0], year_out[20:9], month_out[24:21], mday_out[29:25],
    //        hour_out[34:30], minute_out[40:35], second_out[46:41], zero[47]
    output logic [rdc_pkg::OutDataW-1:0] m_axis_tdata,
    // tuser: status[0]
    output logic [0:0]                   m_axis_tuser
);
    import rdc_pkg::*;

    logic [YearW-1:0] epoch_reg;
    logic             adv;

    // Configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg <= EpochReset;
        end else if (cfg_valid) begin
            epoch_reg <= cfg_data;
        end
    end

    // Front end
    logic      chain_valid [NumCells+1];
    rdc_item_t chain_item  [NumCells+1];

    rdc_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_axis_tvalid),
        .op         (op_t'(s_axis_tuser[0])),
        .year       (s_axis_tdata[11:0]),
        .month      (s_axis_tdata[15:12]),
        .mday       (s_axis_tdata[20:16]),
        .hour       (s_axis_tdata[25:21]),
        .minute     (s_axis_tdata[31:26]),
        .second     (s_axis_tdata[37:32]),
        .day_count  (s_axis_tdata[46:38]),
        .epoch_year (epoch_reg),
        .out_valid  (chain_valid[0]),
        .out_item   (chain_item[0])
    );

    // Row of month-step cells
    for (genvar i = 0; i < NumCells; i++) begin : g_cell
        rdc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (chain_valid[i]),
            .in_item   (chain_item[i]),
            .out_valid (chain_valid[i+1]),
            .out_item  (chain_item[i+1])
        );
    end

    // Format the result from the end of the row
    rdc_item_t             last;
    logic                  out_valid_reg;
    logic [OutDataW-1:0]   out_data_reg, out_data_next;
    logic                  out_status_reg, out_status_next;
    logic                  is_dec;

    always_comb begin
        last            = chain_item[NumCells];
        is_dec          = (last.op == OP_DECODE);
        out_status_next = !is_dec && last.bad;
        out_data_next   = '0;
        out_data_next[8:0]   = (!is_dec && !last.bad) ? last.days : '0;
        out_data_next[20:9]  = is_dec ? last.year : '0;
        out_data_next[24:21] = is_dec ? last.mon : '0;
        out_data_next[29:25] = is_dec ? (last.days[MdayW-1:0] + 1'b1) : '0;
        out_data_next[34:30] = last.hour;
        out_data_next[40:35] = last.minute;
        out_data_next[46:41] = last.second;
    end

    // Hold the row while a result waits
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= chain_valid[NumCells];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_status_reg;

`ifndef SYNTH
    a_dec_done: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_valid[NumCells] && (chain_item[NumCells].op == OP_DECODE)
        |-> chain_item[NumCells].days < 9'd31)
        else $error("decode walk not finished at the end of the row");

    a_enc_done: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_valid[NumCells] && (chain_item[NumCells].op == OP_ENCODE) &&
        !chain_item[NumCells].bad
        |-> chain_item[NumCells].mon == chain_item[NumCells].mon_tgt)
        else $error("encode month sum not finished at the end of the row");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while the result register is blocked");
`endif

endmodule
